// ===== hdl/clm_pkg.sv =====
`default_nettype none
package clm_pkg;

  localparam int unsigned MaxHoldersDefault = 16;
  localparam int unsigned MaxWaitersDefault = 16;
  localparam int unsigned ResultLimit       = 16;
  localparam int unsigned ResultCountWidth  = $clog2(ResultLimit + 1);

  typedef enum logic [2:0] {
    STATUS_GRANTED    = 3'd0,
    STATUS_ENQUEUED   = 3'd1,
    STATUS_BUSY       = 3'd2,
    STATUS_IMPOSSIBLE = 3'd3,
    STATUS_NO_ROOM    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOCK,
    ST_HSCAN,
    ST_HSHIFT,
    ST_WFIND,
    ST_WDROP,
    ST_GSCAN,
    ST_GDROP,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic        action;
    logic [7:0]  client_id;
    logic [15:0] quantity;
    logic        may_wait;
  } req_t;

  typedef struct packed {
    logic [7:0] answer_client;
    logic [2:0] status;
    logic       last;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  client;
    logic [15:0] qty;
  } entry_t;

  typedef struct packed {
    logic fits;
    logic too_big;
  } fit_t;

endpackage
`default_nettype wire

// ===== hdl/counting_lock_manager.sv =====
`default_nettype none
// Counting lock manager. A lock request carries a client and a quantity and
// gets exactly one answer: granted when the free units cover it, impossible
// when it asks for more than total_units, enqueued or busy otherwise
// depending on may_wait, and no-room when the needed table is full. A
// release removes the client's newest holding and then walks the waiting
// queue oldest first, granting every waiter that now fits (up to sixteen,
// while the holder table has room), one answer per grant with last set on
// the final one. A release by a client that holds nothing drops its oldest
// waiting entry and answers nothing. The block handles one request at a
// time and holds in_stall high while it works. A lock request is decided
// in ST_LOCK, which waits there for the output register to be free. A
// release is sequenced over the holder and waiter register files through
// one shared fit comparator, one entry per cycle while no grant waits on
// out_stall: it scans down the holders to find the holding, closes the gap
// above it, then tests each waiter in turn and, on a grant, closes the
// queue gap, and finally flushes the final answer, if any.
// total_units may only be written while idle.
module counting_lock_manager import clm_pkg::*; #(
  parameter int unsigned MAX_HOLDERS = MaxHoldersDefault,
  parameter int unsigned MAX_WAITERS = MaxWaitersDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire req_t        in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output rsp_t             out_data,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data
);

  localparam int unsigned HCW = $clog2(MAX_HOLDERS + 1);
  localparam int unsigned WCW = $clog2(MAX_WAITERS + 1);
  localparam int unsigned HAW = (MAX_HOLDERS > 1) ? $clog2(MAX_HOLDERS) : 1;
  localparam int unsigned WAW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int unsigned RCW = ResultCountWidth;

  state_t state, state_next;

  logic [15:0]  total, locked, locked_next;
  logic [HCW-1:0] hcount, hcount_next, hidx, hidx_next;
  logic [WCW-1:0] wcount, wcount_next, widx, widx_next;
  logic [RCW-1:0] nres, nres_next;
  req_t   req;
  logic   pend_valid, pend_valid_next;
  logic [7:0] pend_client, pend_client_next;
  logic   out_valid_next;
  rsp_t   out_data_next;

  logic   in_accept, out_free;

  // Position of the waiter being granted, where the scan resumes.
  logic [WCW-1:0] gpos;

  // Holder and waiter register files: one read and one write each per cycle.
  logic [HAW-1:0] h_rd_addr, h_wr_addr;
  logic [WAW-1:0] w_rd_addr, w_wr_addr;
  entry_t h_rd, w_rd, h_wr, w_wr;
  logic   h_we, w_we;

  logic [15:0] fit_qty;
  fit_t fit;

  logic h_more, w_more, w_shift_more, g_go;

  clm_list #(.DEPTH(MAX_HOLDERS), .AW(HAW)) u_holders (
    .clk(clk), .rd_addr(h_rd_addr), .rd_data(h_rd),
    .wr_en(h_we), .wr_addr(h_wr_addr), .wr_data(h_wr)
  );

  clm_list #(.DEPTH(MAX_WAITERS), .AW(WAW)) u_waiters (
    .clk(clk), .rd_addr(w_rd_addr), .rd_data(w_rd),
    .wr_en(w_we), .wr_addr(w_wr_addr), .wr_data(w_wr)
  );

  // The single fit comparator serves both the lock decision and the
  // release grant scan.
  assign fit_qty = (state == ST_LOCK) ? req.quantity : w_rd.qty;

  clm_fit u_fit (
    .total(total), .locked(locked), .qty(fit_qty), .result(fit)
  );

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Read addresses: scans read the current entry, gap closing reads the
  // entry just above the gap.
  always_comb begin
    h_rd_addr = (state == ST_HSCAN) ? HAW'(hidx - HCW'(1)) : HAW'(hidx + HCW'(1));
    w_rd_addr = (state == ST_WDROP || state == ST_GDROP) ?
                WAW'(widx + WCW'(1)) : WAW'(widx);
  end

  // Holding still to close above the current position.
  assign h_more       = (hidx + HCW'(1)) < hcount;
  assign w_shift_more = (widx + WCW'(1)) < wcount;
  assign w_more       = widx < wcount;
  assign g_go         = w_more && (nres < RCW'(ResultLimit)) &&
                        (hcount < HCW'(MAX_HOLDERS));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = in_data.action ? ST_HSCAN : ST_LOCK;
        end
      end
      ST_LOCK: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_HSCAN: begin
        if (hidx == '0) begin
          state_next = ST_WFIND;
        end else if (h_rd.client == req.client_id) begin
          state_next = ST_HSHIFT;
        end
      end
      ST_HSHIFT: begin
        if (!h_more) begin
          state_next = ST_GSCAN;
        end
      end
      ST_WFIND: begin
        if (!w_more) begin
          state_next = ST_IDLE;
        end else if (w_rd.client == req.client_id) begin
          state_next = ST_WDROP;
        end
      end
      ST_WDROP: begin
        if (!w_shift_more) begin
          state_next = ST_IDLE;
        end
      end
      ST_GSCAN: begin
        if (!g_go) begin
          state_next = ST_FLUSH;
        end else if (fit.fits && (!pend_valid || out_free)) begin
          state_next = ST_GDROP;
        end
      end
      ST_GDROP: begin
        if (!w_shift_more) begin
          state_next = ST_GSCAN;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and output values.
  always_comb begin
    locked_next      = locked;
    hcount_next      = hcount;
    hidx_next        = hidx;
    wcount_next      = wcount;
    widx_next        = widx;
    nres_next        = nres;
    pend_valid_next  = pend_valid;
    pend_client_next = pend_client;
    out_valid_next   = out_valid && out_stall;
    out_data_next    = out_data;
    h_we             = 1'b0;
    h_wr_addr        = HAW'(hidx);
    h_wr             = h_rd;
    w_we             = 1'b0;
    w_wr_addr        = WAW'(widx);
    w_wr             = w_rd;
    unique case (state)
      ST_IDLE: begin
        hidx_next = hcount;
        widx_next = '0;
        nres_next = '0;
      end
      ST_LOCK: begin
        if (out_free) begin
          out_valid_next              = 1'b1;
          out_data_next.answer_client = req.client_id;
          out_data_next.last          = 1'b1;
          if (fit.fits) begin
            if (hcount >= HCW'(MAX_HOLDERS)) begin
              out_data_next.status = STATUS_NO_ROOM;
            end else begin
              out_data_next.status = STATUS_GRANTED;
              h_we        = 1'b1;
              h_wr_addr   = HAW'(hcount);
              h_wr.client = req.client_id;
              h_wr.qty    = req.quantity;
              hcount_next = hcount + HCW'(1);
              locked_next = locked + req.quantity;
            end
          end else if (fit.too_big) begin
            out_data_next.status = STATUS_IMPOSSIBLE;
          end else if (req.may_wait) begin
            if (wcount >= WCW'(MAX_WAITERS)) begin
              out_data_next.status = STATUS_NO_ROOM;
            end else begin
              out_data_next.status = STATUS_ENQUEUED;
              w_we        = 1'b1;
              w_wr_addr   = WAW'(wcount);
              w_wr.client = req.client_id;
              w_wr.qty    = req.quantity;
              wcount_next = wcount + WCW'(1);
            end
          end else begin
            out_data_next.status = STATUS_BUSY;
          end
        end
      end
      ST_HSCAN: begin
        if (hidx != '0) begin
          hidx_next = hidx - HCW'(1);
          if (h_rd.client == req.client_id) begin
            locked_next = (locked >= h_rd.qty) ? (locked - h_rd.qty) : '0;
          end
        end
      end
      ST_HSHIFT: begin
        if (h_more) begin
          h_we      = 1'b1;
          hidx_next = hidx + HCW'(1);
        end else begin
          hcount_next = hcount - HCW'(1);
        end
      end
      ST_WFIND: begin
        if (w_more && w_rd.client != req.client_id) begin
          widx_next = widx + WCW'(1);
        end
      end
      ST_WDROP, ST_GDROP: begin
        if (w_shift_more) begin
          w_we      = 1'b1;
          widx_next = widx + WCW'(1);
        end else begin
          wcount_next = wcount - WCW'(1);
          // A grant keeps scanning at the position it was found.
          widx_next   = (state == ST_GDROP) ? gpos : widx;
        end
      end
      ST_GSCAN: begin
        if (g_go) begin
          if (!fit.fits) begin
            widx_next = widx + WCW'(1);
          end else if (!pend_valid || out_free) begin
            if (pend_valid) begin
              out_valid_next = 1'b1;
              out_data_next  = '{answer_client: pend_client,
                                 status: STATUS_GRANTED, last: 1'b0};
            end
            pend_valid_next  = 1'b1;
            pend_client_next = w_rd.client;
            h_we        = 1'b1;
            h_wr_addr   = HAW'(hcount);
            h_wr        = w_rd;
            hcount_next = hcount + HCW'(1);
            locked_next = locked + w_rd.qty;
            nres_next   = nres + RCW'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (pend_valid && out_free) begin
          out_valid_next  = 1'b1;
          out_data_next   = '{answer_client: pend_client,
                              status: STATUS_GRANTED, last: 1'b1};
          pend_valid_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      total      <= '0;
      locked     <= '0;
      hcount     <= '0;
      wcount     <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      locked     <= locked_next;
      hcount     <= hcount_next;
      wcount     <= wcount_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
      if (cfg_we) begin
        total <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req <= in_data;
    end
    if (state == ST_GSCAN) begin
      gpos <= widx;
    end
    hidx        <= hidx_next;
    widx        <= widx_next;
    nres        <= nres_next;
    pend_client <= pend_client_next;
    out_data    <= out_data_next;
  end

`ifndef SYNTHESIS
  a_hcount_bound: assert property (@(posedge clk) disable iff (rst)
    hcount <= HCW'(MAX_HOLDERS)) else $error("holder count overflow");
  a_wcount_bound: assert property (@(posedge clk) disable iff (rst)
    wcount <= WCW'(MAX_WAITERS)) else $error("waiter count overflow");
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_valid) else $error("grant left pending");
  a_grant_limit: assert property (@(posedge clk) disable iff (rst)
    state == ST_GSCAN |-> nres <= RCW'(ResultLimit)) else $error("too many grants");
`endif

endmodule
`default_nettype wire

// ===== hdl/clm_fit.sv =====
`default_nettype none
module clm_fit import clm_pkg::*; (
  input  wire logic [15:0] total,
  input  wire logic [15:0] locked,
  input  wire logic [15:0] qty,
  output fit_t             result
);

  logic [16:0] need;

  // The sum is one bit wider so that it cannot wrap.
  assign need           = {1'b0, locked} + {1'b0, qty};
  assign result.fits    = ({1'b0, total} >= need);
  assign result.too_big = (qty > total);

endmodule
`default_nettype wire

// ===== hdl/clm_list.sv =====
`default_nettype none
module clm_list import clm_pkg::*; #(
  parameter int unsigned DEPTH = MaxHoldersDefault,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data
);

  entry_t regs [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      regs[wr_addr] <= wr_data;
    end
  end

  assign rd_data = regs[rd_addr];

endmodule
`default_nettype wire
